@@ src/mtfs_pkg.sv @@
package mtfs_pkg;

  // Payload digit and frame layout
  localparam int DIGIT_W     = 7;
  localparam int BYTE_W      = 8;
  localparam int HDR_W       = 70;
  localparam int HDR_DIGITS  = HDR_W / DIGIT_W;
  localparam int AXIS_W      = 16;
  localparam int AXIS_DIG_W  = 3 * DIGIT_W;
  localparam int MAX_AXES    = 8;
  localparam int IN_DATA_W   = 192;
  localparam int CNT_W       = 4;

  // Command byte after reset
  localparam logic [BYTE_W-1:0] CMD_INIT = 8'd128;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [DIGIT_W-1:0] digit_t;

endpackage

@@ src/motion_task_frame_serializer.sv @@
// Motion task frame serializer. Each task word accepted on in_ is sent on out_ as a
// byte frame: the command byte held in the cfg_ register, ten 7-bit bytes carrying
// task id, direction bits, total steps, deceleration steps, non-zero axis mask and
// step rate (most significant bit first), then three 7-bit bytes (bits 15..14, 13..7,
// 6..0) for each axis with a non-zero step count, lowest axis first. out_tlast marks
// the last byte. A 70-bit shift register feeds the header one 7-bit digit per cycle
// while the output register can take a byte, a 21-bit shift register does the same
// for each axis count, and the axis counts themselves shift out 16 bits per visit.
// The output register lets the next task be accepted while the final byte still waits.
module motion_task_frame_serializer
  import mtfs_pkg::*;
#(
  parameter int AXES = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // tdata: task_id[6:0], dir_bits[14:7], total_steps[30:15], decel_steps[45:31],
  //        step_rate[61:46], axis_steps_low[125:62], axis_steps_high[189:126], zero fill
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  // tdata: out_byte[7:0]; tlast: frame_end
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [BYTE_W-1:0]    out_tdata,
  output logic                 out_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [BYTE_W-1:0]    cfg_data
);

  localparam int AXB_W = AXES * AXIS_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMD  = 3'd1;
  localparam logic [2:0] S_HDR  = 3'd2;
  localparam logic [2:0] S_AXIS = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  localparam logic [CNT_W-1:0] HDR_LAST = CNT_W'(HDR_DIGITS - 1);
  localparam logic [1:0]       PH_LAST  = 2'd2;

  logic [2:0]            state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [1:0]            phase_r, phase_nxt;
  logic [HDR_W-1:0]      hdr_r, hdr_nxt;
  logic [AXB_W-1:0]      axes_r, axes_nxt;
  logic [AXES-1:0]       mask_r, mask_nxt;
  logic [AXIS_DIG_W-1:0] dig_r, dig_nxt;
  byte_t                 cmd_r;
  logic                  out_valid_r, out_valid_nxt;
  byte_t                 out_data_r, out_data_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [2*64-1:0]       axes_all;
  logic [AXES-1:0]       in_mask;
  logic                  can_load;

  // Unpack the axis counts and build the non-zero mask
  assign axes_all = in_tdata[189:62];

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      in_mask[i] = |axes_all[i*AXIS_W +: AXIS_W];
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign can_load   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // Sequence the frame one word per step
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    phase_nxt     = phase_r;
    hdr_nxt       = hdr_r;
    axes_nxt      = axes_r;
    mask_nxt      = mask_r;
    dig_nxt       = dig_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          hdr_nxt   = {in_tdata[6:0], in_tdata[14:7], in_tdata[30:15], in_tdata[45:31],
                       BYTE_W'(in_mask), in_tdata[61:46]};
          axes_nxt  = axes_all[AXB_W-1:0];
          mask_nxt  = in_mask;
          state_nxt = S_CMD;
        end
      end
      S_CMD: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = cmd_r;
          out_last_nxt  = 1'b0;
          cnt_nxt       = '0;
          state_nxt     = S_HDR;
        end
      end
      S_HDR: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, hdr_r[HDR_W-1 -: DIGIT_W]};
          out_last_nxt  = (cnt_r == HDR_LAST) && (mask_r == '0);
          hdr_nxt       = hdr_r << DIGIT_W;
          cnt_nxt       = cnt_r + 1'b1;
          if (cnt_r == HDR_LAST) begin
            state_nxt = (mask_r == '0) ? S_IDLE : S_AXIS;
          end
        end
      end
      S_AXIS: begin
        // Visit the next axis; load its count when it is non-zero
        if (mask_r[0]) begin
          dig_nxt   = AXIS_DIG_W'(axes_r[AXIS_W-1:0]);
          phase_nxt = '0;
          state_nxt = S_EMIT;
        end
        axes_nxt = axes_r >> AXIS_W;
        mask_nxt = mask_r >> 1;
      end
      S_EMIT: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, dig_r[AXIS_DIG_W-1 -: DIGIT_W]};
          out_last_nxt  = (phase_r == PH_LAST) && (mask_r == '0);
          dig_nxt       = dig_r << DIGIT_W;
          phase_nxt     = phase_r + 1'b1;
          if (phase_r == PH_LAST) begin
            state_nxt = (mask_r == '0) ? S_IDLE : S_AXIS;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cmd_r       <= CMD_INIT;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cmd_r <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    phase_r    <= phase_nxt;
    hdr_r      <= hdr_nxt;
    axes_r     <= axes_nxt;
    mask_r     <= mask_nxt;
    dig_r      <= dig_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  // Checks
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_CMD)
    else $error("accepted task did not start a frame");

  a_axis_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_AXIS |-> mask_r != '0)
    else $error("axis scan with no non-zero axis left");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> phase_r != 2'd3)
    else $error("axis digit phase out of range");

  a_hdr_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_HDR |-> cnt_r <= HDR_LAST)
    else $error("header digit count out of range");

endmodule
